[rtl/core/uhb_pkg.sv]
// uhb_pkg: shared types and constants for the uniform histogram binner.
// Used by uhb_frac_div and uniform_histogram_binner_core; no dependencies.
package uhb_pkg;

  localparam int SAMPLE_W  = 32;  // signed Q16.16 sample
  localparam int WIDTH_W   = 31;  // bin span register, unsigned Q15.16
  localparam int BCNT_W    = 7;   // bin_count register
  localparam int FRAC_W    = 17;  // Q1.16 fraction, one is 2^16
  localparam int EDGE_W    = 37;  // bin upper edge, unsigned Q21.16
  localparam int QUO_BITS  = 17;  // quotient bits the divider produces
  localparam int OUT_DATA_W = 56; // fraction + edge padded to whole bytes

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SPAN  = 1'b1;

  // Input item kind, carried on in_tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_EMIT   = 1'b1;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/core/uhb_frac_div.sv]
// uhb_frac_div: restoring divider, one quotient bit per cycle, for the
// (count*65536 + total/2) / total fraction. Depends on uhb_pkg.
module uhb_frac_div #(
  parameter int COUNT_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [COUNT_BITS-1:0]        count,
  input  logic [COUNT_BITS-1:0]        total,
  output uhb_pkg::div_stat_t           stat,
  output logic [uhb_pkg::QUO_BITS-1:0] quot
);

  localparam int NUM_W = COUNT_BITS + 16;
  localparam int QB    = uhb_pkg::QUO_BITS;
  localparam int CNT_W = $clog2(QB);

  logic [NUM_W-1:0]      num;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   rem_sub;
  logic                  ge;
  logic [COUNT_BITS-1:0] rem_r;
  logic [QB-1:0]         shl_r;   // numerator low bits in, quotient bits out
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  // count <= total keeps the quotient within 17 bits, so the top part of
  // the numerator is already below the divisor.
  assign num     = {count, 16'b0} + NUM_W'(total >> 1);
  assign rem_sh  = {rem_r, shl_r[QB-1]};
  assign rem_sub = rem_sh - {1'b0, total};
  assign ge      = (rem_sh >= {1'b0, total});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= COUNT_BITS'(num[NUM_W-1:QB]);
      shl_r <= num[QB-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      shl_r <= {shl_r[QB-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = shl_r;

endmodule

[rtl/core/uniform_histogram_binner_core.sv]
// uniform_histogram_binner_core: equal-width histogram over Q16.16 samples.
// Sample item: only counted in the total if negative or span zero; otherwise the edges are
// walked to bin k, or to no bin above the top edge. Emit: a 17-step divider run per bin.
// One item at a time; in_tready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous): counts and total read as zero, bin_count 64,
// bin span 1.0; count memory is covered by valid bits. Uses uhb_pkg, uhb_frac_div.
module uniform_histogram_binner_core #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [uhb_pkg::SAMPLE_W-1:0]      in_tdata,  // [31:0] sample
  input  logic                              in_tuser,  // [0] kind
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [uhb_pkg::OUT_DATA_W-1:0]    out_tdata, // [16:0] bin_fraction,
                                                       // [53:17] bin_upper_edge
  output logic                              out_tlast, // last_bin
  // configuration
  input  logic                              cfg_we,
  input  logic [uhb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uhb_pkg::WIDTH_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int EW    = uhb_pkg::EDGE_W;
  localparam int FW    = uhb_pkg::FRAC_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,   // walk bin edges with the shared adder/comparator
    ST_UPDATE,   // read-modify-write of the hit bin
    ST_EMIT_RD,  // address count memory
    ST_EMIT_LD,  // start divider with the read count
    ST_EMIT_DIV, // wait for quotient
    ST_EMIT_OUT  // hand result to output register
  } state_t;

  state_t state_r;

  // configuration
  logic [uhb_pkg::BCNT_W-1:0]  bin_count_r;
  logic [uhb_pkg::WIDTH_W-1:0] bin_span_r;

  // working registers
  logic [IDX_W-1:0]             k_r;      // current bin index
  logic [EW-1:0]                acc_r;    // running edge (k+1)*w
  logic [uhb_pkg::WIDTH_W-1:0]  sample_r; // non-negative sample magnitude
  logic [COUNT_BITS-1:0]        total_r;
  logic [MAX_BINS-1:0]          vld_r;    // bin entry written since last clear

  // count memory
  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;

  // output register
  logic                  out_tvalid_r;
  logic [FW-1:0]         out_frac_r;
  logic [EW-1:0]         out_edge_r;
  logic                  out_last_r;

  // shared edge unit
  logic [EW-1:0]         acc_sum;
  logic [EW-1:0]         sample_ext;
  logic                  smp_lt;
  logic                  smp_eq;

  logic [IDX_W-1:0]             last_idx;
  logic [uhb_pkg::BCNT_W-1:0]   bc_m1;
  logic                         in_acc;
  logic                         out_free;
  logic                         out_load;
  logic                         div_start;
  uhb_pkg::div_stat_t           div_stat;
  logic [uhb_pkg::QUO_BITS-1:0] div_quot;
  logic [FW-1:0]                frac_val;

  // bins in use: zero means one, above MAX_BINS clamps
  assign bc_m1 = bin_count_r - uhb_pkg::BCNT_W'(1);
  always_comb begin
    priority if (bin_count_r == '0)
      last_idx = '0;
    else if (bin_count_r > uhb_pkg::BCNT_W'(MAX_BINS))
      last_idx = IDX_W'(MAX_BINS - 1);
    else
      last_idx = IDX_W'(bc_m1);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  // a result moves into the output register this cycle
  assign out_load  = (state_r == ST_EMIT_OUT) && out_free;

  assign acc_sum    = acc_r + EW'(bin_span_r);
  assign sample_ext = EW'(sample_r);
  assign smp_lt     = (sample_ext < acc_r);
  assign smp_eq     = (sample_ext == acc_r);

  assign cur_cnt = vld_r[k_r] ? mem_q_r : '0;
  assign cnt_inc = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + COUNT_BITS'(1);
  assign mem_we  = (state_r == ST_UPDATE);

  assign div_start = (state_r == ST_EMIT_LD);

  // zero total reports zero; clamp to one as a guard
  always_comb begin
    priority if (total_r == '0)
      frac_val = '0;
    else if (div_quot > uhb_pkg::FRAC_ONE)
      frac_val = uhb_pkg::FRAC_ONE;
    else
      frac_val = div_quot;
  end

  uhb_frac_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .count (cur_cnt),
    .total (total_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // count memory: one write, one registered read at k_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[k_r] <= cnt_inc;
    end
    mem_q_r <= mem[k_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= uhb_pkg::BCNT_W'(64);
      bin_span_r  <= uhb_pkg::WIDTH_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        uhb_pkg::CFG_BIN_COUNT: bin_count_r <= cfg_wdata[uhb_pkg::BCNT_W-1:0];
        uhb_pkg::CFG_BIN_SPAN:  bin_span_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
      k_r          <= '0;
      acc_r        <= '0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            k_r   <= '0;
            acc_r <= EW'(bin_span_r);
            if (in_tuser == uhb_pkg::KIND_EMIT) begin
              state_r <= ST_EMIT_RD;
            end else begin
              total_r  <= (total_r == CNT_MAX) ? CNT_MAX : total_r + COUNT_BITS'(1);
              sample_r <= in_tdata[uhb_pkg::WIDTH_W-1:0];
              // negative samples and a zero span only count in the total
              if (!in_tdata[uhb_pkg::SAMPLE_W-1] && (bin_span_r != '0)) begin
                state_r <= ST_SEARCH;
              end
            end
          end
        end
        ST_SEARCH: begin
          priority if (smp_lt) begin
            state_r <= ST_UPDATE;
          end else if (k_r == last_idx) begin
            // top edge belongs to the last bin
            state_r <= smp_eq ? ST_UPDATE : ST_IDLE;
          end else begin
            k_r   <= k_r + IDX_W'(1);
            acc_r <= acc_sum;
          end
        end
        ST_UPDATE: begin
          vld_r[k_r] <= 1'b1;
          state_r    <= ST_IDLE;
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          state_r <= ST_EMIT_DIV;
        end
        ST_EMIT_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_EMIT_OUT;
          end
        end
        ST_EMIT_OUT: begin
          if (out_load) begin
            out_frac_r   <= frac_val;
            out_edge_r   <= acc_r;
            out_last_r   <= (k_r == last_idx);
            if (k_r == last_idx) begin
              vld_r   <= '0;
              total_r <= '0;
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + IDX_W'(1);
              acc_r   <= acc_sum;
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = uhb_pkg::OUT_DATA_W'({out_edge_r, out_frac_r});
  assign out_tlast  = out_last_r;

  // results appear only from the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_EMIT_OUT))
    else $error("result appeared outside emit");

  // quotient is only taken while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_EMIT_DIV))
    else $error("divider finished while sequencer not waiting");

  // edge walk never passes the last bin in use
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (k_r <= last_idx))
    else $error("edge walk beyond last bin");

  // starting a division is never done on a busy divider
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for uniform_histogram_binner_core.
// Depends on uhb_pkg and the core RTL; holds its own histogram predictor.
module testbench;

  localparam int MAX_BINS      = 64;
  localparam int CNT_BITS      = 24;
  localparam int RANDOM_ITEMS  = 88;
  localparam int SETTLE_CYCLES = 80;     // long enough for the longest sample edge walk
  localparam int DRAIN_CYCLES  = 100;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam int FRAC_W  = uhb_pkg::FRAC_W;
  localparam int EDGE_W  = uhb_pkg::EDGE_W;
  localparam int SMP_W   = uhb_pkg::SAMPLE_W;
  localparam int SPAN_W  = uhb_pkg::WIDTH_W;
  localparam int BCNT_W  = uhb_pkg::BCNT_W;

  typedef struct packed {
    logic [FRAC_W-1:0] bin_fraction;
    logic [EDGE_W-1:0] upper_edge;
    logic              is_last;
  } bin_result_t;

  typedef enum logic [1:0] {OP_SET_COUNT, OP_SET_SPAN, OP_SAMPLE, OP_EMIT} stim_op_t;

  // typed: expected first result of an emit given by hand; the other bins come
  // from the predictor.
  typedef struct packed {
    stim_op_t          op;
    logic [31:0]       value;
    logic              typed;
    logic [FRAC_W-1:0] exp_frac;
    logic [EDGE_W-1:0] exp_edge;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 31;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [SMP_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [uhb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we;
  logic [uhb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [SPAN_W-1:0] cfg_wdata;

  uniform_histogram_binner_core #(
    .MAX_BINS  (MAX_BINS),
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] sample
    .in_tuser  (in_tuser),   // [0] kind
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [16:0] bin_fraction, [53:17] bin_upper_edge
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the counts, the total and both registers.
  // ---------------------------------------------------------------------------
  logic [CNT_BITS-1:0] bin_tally [MAX_BINS];
  logic [CNT_BITS-1:0] sample_tally;
  logic [BCNT_W-1:0]   cur_bin_count;
  logic [SPAN_W-1:0]   cur_bin_span;

  bin_result_t due_bins [$];   // results owed by the block, oldest first

  int errors;
  int items_sent;
  int results_seen;
  int reg_writes;
  int cycles;
  int burst_left;
  bit steady_sender;
  bit hold_armed;
  bit hold_done;

  // Zero bins means one, anything above the store depth means the full store.
  function automatic int bins_in_effect();
    if (cur_bin_count == '0) return 1;
    if (int'(cur_bin_count) > MAX_BINS) return MAX_BINS;
    return int'(cur_bin_count);
  endfunction

  // Applies one accepted item: a sample updates the tallies, an emit queues one
  // result per bin in use and then clears everything (hidden bins too).
  task automatic update_histogram(input logic kind, input logic [SMP_W-1:0] sample,
                                  input logic typed, input logic [FRAC_W-1:0] typed_frac,
                                  input logic [EDGE_W-1:0] typed_edge);
    int          n;
    logic [63:0] w;
    logic [63:0] raw;
    logic [63:0] upper;
    logic [63:0] idx;
    logic [63:0] frac;
    bin_result_t r;
    n = bins_in_effect();
    w = 64'(cur_bin_span);
    if (kind == uhb_pkg::KIND_SAMPLE) begin
      raw   = 64'(sample);
      upper = 64'(n) * w;
      if (sample_tally != '1) sample_tally = sample_tally + 1'b1;
      // negatives and a zero span only count toward the total
      if (!sample[SMP_W-1] && w != 64'd0) begin
        if (raw < upper) idx = raw / w;
        else if (raw == upper) idx = 64'(n - 1);   // top edge closes the last bin
        else idx = 64'(MAX_BINS);                  // above the range: no bin
        if (idx < 64'(MAX_BINS) && bin_tally[idx] != '1)
          bin_tally[idx] = bin_tally[idx] + 1'b1;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        frac = 64'd0;
        if (sample_tally != '0) begin
          // round to nearest, ties up
          frac = (64'(bin_tally[i]) * 64'd65536 + 64'(sample_tally) / 64'd2)
                 / 64'(sample_tally);
          if (frac > 64'd65536) frac = 64'd65536;
        end
        r.bin_fraction = frac[FRAC_W-1:0];
        r.upper_edge   = EDGE_W'(64'(i + 1) * w);
        r.is_last      = (i + 1 == n);
        if (i == 0 && typed) begin
          r.bin_fraction = typed_frac;
          r.upper_edge   = typed_edge;
        end
        due_bins.push_back(r);
      end
      foreach (bin_tally[i]) bin_tally[i] = '0;
      sample_tally = '0;
    end
  endtask

  // Random sample shaped for the current setting: mostly inside the bins and
  // on their edges, the rest negative, just above the range or fully random.
  function automatic logic [SMP_W-1:0] pick_sample();
    int          n;
    logic [63:0] w;
    logic [63:0] lim;
    logic [63:0] v;
    n   = bins_in_effect();
    w   = 64'(cur_bin_span);
    lim = 64'(n) * w;
    if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = {32'b0, $urandom()} % (lim + 64'd1);
      4, 5: begin
        v = 64'($urandom_range(0, n)) * w;
        if (v > lim) v = lim;
      end
      6: begin
        v = 64'($urandom_range(1, n)) * w - 64'd1;
        if (v > lim) v = lim;
      end
      7: v = lim + 64'd1;
      8: v = {32'b0, 1'b1, 31'($urandom())};
      default: v = {32'b0, $urandom()};
    endcase
    return v[SMP_W-1:0];
  endfunction

  // One item on the input channel. Prediction happens at the accepting edge;
  // afterwards the sender may take a gap, ending its current burst.
  task automatic send_item(input logic kind, input logic [SMP_W-1:0] data,
                           input logic typed = 1'b0,
                           input logic [FRAC_W-1:0] typed_frac = '0,
                           input logic [EDGE_W-1:0] typed_edge = '0);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    update_histogram(kind, data, typed, typed_frac, typed_edge);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 8);
      gap = steady_sender ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Register write with the block idle: every owed result delivered, then a
  // pause long enough for a trailing sample walk to finish.
  task automatic write_reg(input logic [uhb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (due_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[SPAN_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == uhb_pkg::CFG_BIN_COUNT) cur_bin_count = value[BCNT_W-1:0];
    else cur_bin_span = value[SPAN_W-1:0];
    reg_writes++;
  endtask

  // Directed rows: reset state, field extremes, both register extremes and
  // their clamping, zero span, the top edge of the last bin, out-of-range and
  // negative samples, and counts left behind in bins hidden by a smaller count.
  stim_row_t directed [DIRECTED_ROWS] = '{
    // defaults after reset: 64 bins of 1.0, nothing counted
    '{OP_EMIT,      32'h0000_0000, 1'b1, 17'd0,     37'd65536},
    '{OP_SAMPLE,    32'h0000_0000, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h0000_FFFF, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h0001_0000, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h0040_0000, 1'b0, 17'd0,     37'd0},  // exactly the top edge
    '{OP_SAMPLE,    32'h0040_0001, 1'b0, 17'd0,     37'd0},  // just above
    '{OP_SAMPLE,    32'h8000_0000, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'hFFFF_FFFF, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h7FFF_FFFF, 1'b0, 17'd0,     37'd0},
    '{OP_EMIT,      32'hFFFF_FFFF, 1'b1, 17'd16384, 37'd65536},
    // zero bins acts as one, widest bin
    '{OP_SET_COUNT, 32'd0,         1'b0, 17'd0,     37'd0},
    '{OP_SET_SPAN,  32'h7FFF_FFFF, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h7FFF_FFFF, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h0000_0000, 1'b0, 17'd0,     37'd0},
    '{OP_EMIT,      32'h0000_0000, 1'b1, 17'd65536, 37'h7FFF_FFFF},
    // count above the store clamps to 64, zero span bins nothing
    '{OP_SET_COUNT, 32'd127,       1'b0, 17'd0,     37'd0},
    '{OP_SET_SPAN,  32'd0,         1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h0000_0005, 1'b0, 17'd0,     37'd0},
    '{OP_EMIT,      32'h1234_5678, 1'b1, 17'd0,     37'd0},
    // largest edges: 64 bins of maximum span
    '{OP_SET_COUNT, 32'd64,        1'b0, 17'd0,     37'd0},
    '{OP_SET_SPAN,  32'h7FFF_FFFF, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h7FFF_FFFE, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h7FFF_FFFF, 1'b0, 17'd0,     37'd0},
    '{OP_EMIT,      32'h0000_0000, 1'b0, 17'd0,     37'd0},
    // bin 3 filled, then hidden by a count of 2; the emit still clears it
    '{OP_SET_COUNT, 32'd4,         1'b0, 17'd0,     37'd0},
    '{OP_SET_SPAN,  32'h0001_0000, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h0003_8000, 1'b0, 17'd0,     37'd0},
    '{OP_SAMPLE,    32'h0000_0000, 1'b0, 17'd0,     37'd0},
    '{OP_SET_COUNT, 32'd2,         1'b0, 17'd0,     37'd0},
    '{OP_EMIT,      32'h0000_0000, 1'b0, 17'd0,     37'd0},
    '{OP_SET_COUNT, 32'd4,         1'b0, 17'd0,     37'd0}
  };

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycles, due_bins.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern of its own, plus one long hold-off while the
  // sender keeps offering items so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : result_pacer
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done && out_tvalid) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;                           // no stalls
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);    // heavy stalls
        default: out_tready <= ~out_tready;
      endcase
    end
  end

  // Each delivered result against the oldest owed one, field by field.
  always @(posedge clk) begin : result_check
    bin_result_t got;
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.bin_fraction = out_tdata[FRAC_W-1:0];
      got.upper_edge   = out_tdata[FRAC_W+EDGE_W-1:FRAC_W];
      got.is_last      = out_tlast;
      results_seen++;
      if (due_bins.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR cycle %0d: unexpected result frac=%0d edge=%0h last=%0b",
                   cycles, got.bin_fraction, got.upper_edge, got.is_last);
      end else begin
        want = due_bins.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("ERROR cycle %0d: exp/got frac %0d/%0d edge %0h/%0h last %0b/%0b",
                     cycles, want.bin_fraction, got.bin_fraction, want.upper_edge,
                     got.upper_edge, want.is_last, got.is_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t row;
    int        random_items;
    int        nsamp;
    logic [31:0] count_val;
    logic [31:0] span_val;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = uhb_pkg::KIND_SAMPLE;
    cfg_we     = 1'b0;
    cfg_index  = uhb_pkg::CFG_BIN_COUNT;
    cfg_wdata  = '0;
    items_sent = 0;
    reg_writes = 0;
    burst_left = 0;
    steady_sender = 1'b0;
    hold_armed = 1'b0;
    hold_done  = 1'b0;
    random_items = 0;

    // predictor reset state
    foreach (bin_tally[i]) bin_tally[i] = '0;
    sample_tally  = '0;
    cur_bin_count = BCNT_W'(64);
    cur_bin_span  = SPAN_W'(65536);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (directed[r]) begin
      row = directed[r];
      case (row.op)
        OP_SET_COUNT: write_reg(uhb_pkg::CFG_BIN_COUNT, row.value);
        OP_SET_SPAN:  write_reg(uhb_pkg::CFG_BIN_SPAN, row.value);
        OP_SAMPLE:    send_item(uhb_pkg::KIND_SAMPLE, row.value);
        default:      send_item(uhb_pkg::KIND_EMIT, row.value, row.typed, row.exp_frac,
                                row.exp_edge);
      endcase
    end

    // random part: per phase maybe a new setting, a run of samples, an emit
    for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: count_val = 32'd0;
          1: count_val = 32'd127;
          2: count_val = 32'(MAX_BINS);
          3: count_val = 32'($urandom_range(0, 127));
          default: count_val = 32'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 5))
          0: span_val = 32'h7FFF_FFFF;
          1: span_val = 32'h0001_0000;
          default: span_val = $urandom() >> $urandom_range(1, 31);
        endcase
        write_reg(uhb_pkg::CFG_BIN_COUNT, count_val);
        write_reg(uhb_pkg::CFG_BIN_SPAN, span_val);
      end
      steady_sender = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // results of this emit get held; the samples behind it must back up
        hold_armed = 1'b1;
        send_item(uhb_pkg::KIND_EMIT, $urandom());
        random_items++;
      end
      nsamp = $urandom_range(0, 14);
      repeat (nsamp) begin
        send_item(uhb_pkg::KIND_SAMPLE, pick_sample());
        random_items++;
      end
      send_item(uhb_pkg::KIND_EMIT, $urandom());
      random_items++;
    end

    in_tvalid <= 1'b0;
    while (due_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d items, %0d register writes, %0d bin results checked, %0d mismatches",
             items_sent, reg_writes, results_seen, errors);
    $display("Covered bin counts 0..127, spans 0..max, edge hits, stalls and a long hold");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
